/* src/sfha_pkg.sv */
// shared types, codes and tag constants of the segregated-fit heap allocator
`default_nettype none

package sfha_pkg;

   typedef logic [31:0] word_type;

   // boundary tag layout
   localparam word_type WSIZE        = 32'd4;
   localparam word_type DSIZE        = 32'd8;
   localparam word_type MIN_BLOCK    = 32'd24;
   localparam word_type TAG_MASK     = 32'h7;
   localparam word_type START_END    = 32'd16;
   localparam word_type SMALL_LIMIT  = 32'd16;
   localparam word_type ROUND_ADD    = 32'd15;
   localparam word_type PROLOGUE_TAG = 32'h9;
   localparam word_type EPILOGUE_TAG = 32'h1;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE         = 2'd0,
      ST_ZERO_SIZE    = 2'd1,
      ST_NO_MEMORY    = 2'd2,
      ST_FREE_IGNORED = 2'd3
   } status_type;

   // one access to the heap word memory
   typedef struct packed {
      logic     rd;
      logic     wr;
      word_type addr;
      word_type wdata;
   } mem_req_type;

   typedef enum logic [5:0] {
      S_INIT, S_IDLE,
      S_A0, S_ACLS, S_ANODE, S_ACHK, S_ANEXT,
      S_GROW, S_GROW1, S_GROW2,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M7R, S_M8, S_M8R,
      S_M9, S_M10, S_MDONE,
      S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PLDONE,
      S_F0, S_F1, S_F2, S_F3,
      S_MARK0, S_MARK1,
      S_PUSH0, S_PUSH1, S_PUSH2, S_PUSH3,
      S_UNL0, S_UNL1, S_UNL2, S_UNL3, S_UNL4, S_UNL5, S_UNL6
   } seq_state_type;

endpackage

`default_nettype wire

/* src/sfha_channels.sv */
// request and response channel interfaces of the heap allocator
`default_nettype none

interface sfha_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] request_bytes;
   logic [15:0] block_offset;

   modport source (output valid, output command, output request_bytes,
                   output block_offset, input ready);
   modport sink (input valid, input command, input request_bytes,
                 input block_offset, output ready);
endinterface

interface sfha_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_offset;
   logic [16:0] granted_bytes;
   logic [1:0]  status;

   modport source (output valid, output payload_offset, output granted_bytes,
                   output status, input ready);
   modport sink (input valid, input payload_offset, input granted_bytes,
                 input status, output ready);
endinterface

`default_nettype wire

/* src/sfha_heap_mem.sv */
// heap word memory with one access per cycle and zero reads outside the heap
`default_nettype none

module sfha_heap_mem import sfha_pkg::*; #(
   parameter int HEAP_WORDS = 16384
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output word_type    rd_data
);

   localparam int AW = $clog2(HEAP_WORDS);

   word_type       mem [HEAP_WORDS];
   word_type       rd_q_ff;
   logic           oob_ff;
   logic           in_range;
   logic [AW-1:0]  idx;

   // word index and heap bound check
   assign in_range = mem_req.addr[31:2] < 30'(HEAP_WORDS);
   assign idx      = mem_req.addr[AW+1:2];

   // write port, writes past the heap are dropped
   always_ff @(posedge clock) begin
      if (mem_req.wr && in_range) begin
         mem[idx] <= mem_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rd) begin
         rd_q_ff <= mem[idx];
         oob_ff  <= !in_range;
      end
   end

   assign rd_data = oob_ff ? '0 : rd_q_ff;

endmodule

`default_nettype wire

/* src/segregated_fit_heap_allocator_core.sv */
// top level: request sequencer over the heap word memory and list head registers
// throughput: one request at a time, the next is taken once the response register frees
// reset: synchronous; after reset the sequencer first writes the prologue and epilogue
//   tags, during which no request is taken; list heads clear and the heap end is 16
`default_nettype none

module segregated_fit_heap_allocator_core import sfha_pkg::*; #(
   parameter int HEAP_BYTES   = 65536,
   parameter int SIZE_CLASSES = 14
) (
   input  logic       clock,
   input  logic       reset,
   sfha_req_if.sink   req_chan,
   sfha_rsp_if.source rsp_chan
);

   localparam int HEAP_WORDS = HEAP_BYTES / 4;
   localparam int END_W      = $clog2(HEAP_BYTES + 1);
   localparam int CLS_W      = $clog2(SIZE_CLASSES);
   localparam int CNT_W      = $clog2(SIZE_CLASSES + 1);
   localparam int WALK_LIMIT = HEAP_BYTES / 8;
   localparam int BUD_W      = $clog2(WALK_LIMIT + 1);

   // size class: smallest c with 2^c >= s, capped at the last class
   function automatic logic [CLS_W-1:0] class_of(input word_type s);
      logic [CLS_W-1:0] c;
      c = '0;
      for (int i = 0; i < SIZE_CLASSES - 1; i++) begin
         if ((word_type'(1) << i) < s) c = CLS_W'(i + 1);
      end
      return c;
   endfunction

   seq_state_type    state_ff, state_in, ret_ff, ret_in;
   logic [1:0]       init_cnt_ff, init_cnt_in;
   logic             cmd_ff, cmd_in;
   logic [15:0]      req_bytes_ff, req_bytes_in;
   word_type         need_ff, need_in;
   logic [CNT_W-1:0] cls_ff, cls_in;
   logic [BUD_W-1:0] budget_ff, budget_in;
   word_type         p_ff, p_in;
   word_type         mbp_ff, mbp_in;
   word_type         size_ff, size_in;
   word_type         prev_ff, prev_in;
   word_type         next_ff, next_in;
   logic             pa_ff, pa_in;
   logic             na_ff, na_in;
   word_type         hdr_ff, hdr_in;
   word_type         sub_bp_ff, sub_bp_in;
   word_type         sub_size_ff, sub_size_in;
   logic             sub_tag_ff, sub_tag_in;
   word_type         pred_ff, pred_in;
   word_type         succ_ff, succ_in;
   word_type         heads_ff [SIZE_CLASSES];
   word_type         heads_in [SIZE_CLASSES];
   logic [END_W-1:0] heap_end_ff, heap_end_in;
   logic             out_valid_ff, out_valid_in;
   logic [15:0]      out_pay_ff, out_pay_in;
   logic [16:0]      out_gr_ff, out_gr_in;
   status_type       out_st_ff, out_st_in;

   mem_req_type      mem_req;
   word_type         rdv;
   word_type         sz;
   word_type         hend;
   logic [CLS_W-1:0] cv;

   sfha_heap_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rdv)
   );

   assign hend = word_type'(heap_end_ff);
   assign sz   = rdv & ~TAG_MASK;

   // handshake and response register
   assign req_chan.ready          = (state_ff == S_IDLE) && (!out_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.payload_offset = out_pay_ff;
   assign rsp_chan.granted_bytes  = out_gr_ff;
   assign rsp_chan.status         = out_st_ff;

   // sequencer: next state, memory access and register updates
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      init_cnt_in  = init_cnt_ff;
      cmd_in       = cmd_ff;
      req_bytes_in = req_bytes_ff;
      need_in      = need_ff;
      cls_in       = cls_ff;
      budget_in    = budget_ff;
      p_in         = p_ff;
      mbp_in       = mbp_ff;
      size_in      = size_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      pa_in        = pa_ff;
      na_in        = na_ff;
      hdr_in       = hdr_ff;
      sub_bp_in    = sub_bp_ff;
      sub_size_in  = sub_size_ff;
      sub_tag_in   = sub_tag_ff;
      pred_in      = pred_ff;
      succ_in      = succ_ff;
      heads_in     = heads_ff;
      heap_end_in  = heap_end_ff;
      out_valid_in = out_valid_ff;
      out_pay_in   = out_pay_ff;
      out_gr_in    = out_gr_ff;
      out_st_in    = out_st_ff;
      mem_req      = '0;
      cv           = '0;

      if (rsp_chan.ready) out_valid_in = 1'b0;

      unique case (state_ff)
         // prologue and epilogue tags
         S_INIT: begin
            mem_req.wr   = 1'b1;
            mem_req.addr = word_type'(init_cnt_ff) << 2;
            case (init_cnt_ff)
               2'd1, 2'd2: mem_req.wdata = PROLOGUE_TAG;
               2'd3:       mem_req.wdata = EPILOGUE_TAG;
               default:    mem_req.wdata = '0;
            endcase
            init_cnt_in = init_cnt_ff + 2'd1;
            if (init_cnt_ff == 2'd3) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               cmd_in       = req_chan.command;
               req_bytes_in = req_chan.request_bytes;
               mbp_in       = word_type'(req_chan.block_offset);
               out_pay_in   = '0;
               out_gr_in    = '0;
               out_st_in    = ST_DONE;
               state_in     = (req_chan.command == CMD_FREE) ? S_F0 : S_A0;
            end
         end
         // block size and starting class
         S_A0: begin
            if (req_bytes_ff == '0) begin
               out_st_in    = ST_ZERO_SIZE;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (word_type'(req_bytes_ff) <= SMALL_LIMIT) need_in = MIN_BLOCK;
               else need_in = (word_type'(req_bytes_ff) + ROUND_ADD) & ~TAG_MASK;
               cls_in    = CNT_W'(class_of(need_in));
               budget_in = BUD_W'(WALK_LIMIT);
               state_in  = S_ACLS;
            end
         end
         // first-fit walk over the lists
         S_ACLS: begin
            if (cls_ff >= CNT_W'(SIZE_CLASSES)) begin
               state_in = S_GROW;
            end else begin
               p_in     = heads_ff[cls_ff[CLS_W-1:0]];
               state_in = S_ANODE;
            end
         end
         S_ANODE: begin
            if (p_ff == '0 || budget_ff == '0) begin
               cls_in   = cls_ff + 1'b1;
               state_in = S_ACLS;
            end else begin
               budget_in    = budget_ff - 1'b1;
               mem_req.rd   = 1'b1;
               mem_req.addr = p_ff - WSIZE;
               state_in     = S_ACHK;
            end
         end
         S_ACHK: begin
            if (sz >= need_ff) begin
               state_in = S_PL0;
            end else begin
               mem_req.rd   = 1'b1;
               mem_req.addr = p_ff + WSIZE;
               state_in     = S_ANEXT;
            end
         end
         S_ANEXT: begin
            p_in     = rdv;
            state_in = S_ANODE;
         end
         // extend the heap at its end
         S_GROW: begin
            if (need_ff > word_type'(HEAP_BYTES) - hend) begin
               out_st_in    = ST_NO_MEMORY;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               p_in        = hend;
               sub_bp_in   = hend;
               sub_size_in = need_ff;
               sub_tag_in  = 1'b0;
               ret_in      = S_GROW1;
               state_in    = S_MARK0;
            end
         end
         S_GROW1: begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = p_ff + need_ff - WSIZE;
            mem_req.wdata = EPILOGUE_TAG;
            heap_end_in   = heap_end_ff + need_ff[END_W-1:0];
            sub_bp_in     = p_ff;
            ret_in        = S_GROW2;
            state_in      = S_PUSH0;
         end
         S_GROW2: begin
            mbp_in   = p_ff;
            state_in = S_M0;
         end
         // coalesce with free neighbors
         S_M0: begin
            mem_req.rd   = 1'b1;
            mem_req.addr = mbp_ff - WSIZE;
            state_in     = S_M1;
         end
         S_M1: begin
            size_in      = sz;
            mem_req.rd   = 1'b1;
            mem_req.addr = mbp_ff - DSIZE;
            state_in     = S_M2;
         end
         S_M2: begin
            prev_in      = mbp_ff - sz;
            next_in      = mbp_ff + size_ff;
            mem_req.rd   = 1'b1;
            mem_req.addr = prev_in - WSIZE;
            state_in     = S_M3;
         end
         S_M3: begin
            pa_in        = rdv[0];
            mem_req.rd   = 1'b1;
            mem_req.addr = next_ff - WSIZE;
            state_in     = S_M4;
         end
         S_M4: begin
            na_in = rdv[0];
            if (pa_ff && rdv[0]) begin
               state_in = S_MDONE;
            end else if (!pa_ff) begin
               sub_bp_in = prev_ff;
               ret_in    = S_M5;
               state_in  = S_UNL0;
            end else begin
               state_in = S_M5;
            end
         end
         S_M5: begin
            sub_bp_in = mbp_ff;
            ret_in    = S_M6;
            state_in  = S_UNL0;
         end
         S_M6: begin
            if (!na_ff) begin
               sub_bp_in = next_ff;
               ret_in    = S_M7;
               state_in  = S_UNL0;
            end else begin
               state_in = S_M8;
            end
         end
         S_M7: begin
            mem_req.rd   = 1'b1;
            mem_req.addr = next_ff - WSIZE;
            state_in     = S_M7R;
         end
         S_M7R: begin
            size_in  = size_ff + sz;
            state_in = S_M8;
         end
         S_M8: begin
            if (!pa_ff) begin
               mem_req.rd   = 1'b1;
               mem_req.addr = prev_ff - WSIZE;
               state_in     = S_M8R;
            end else begin
               state_in = S_M9;
            end
         end
         S_M8R: begin
            size_in  = size_ff + sz;
            mbp_in   = prev_ff;
            state_in = S_M9;
         end
         S_M9: begin
            sub_bp_in   = mbp_ff;
            sub_size_in = size_ff;
            sub_tag_in  = 1'b0;
            ret_in      = S_M10;
            state_in    = S_MARK0;
         end
         S_M10: begin
            sub_bp_in = mbp_ff;
            ret_in    = S_MDONE;
            state_in  = S_PUSH0;
         end
         S_MDONE: begin
            if (cmd_ff == CMD_FREE) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               p_in     = mbp_ff;
               state_in = S_PL0;
            end
         end
         // place the request, splitting off a remainder of at least MIN_BLOCK bytes
         S_PL0: begin
            sub_bp_in = p_ff;
            ret_in    = S_PL1;
            state_in  = S_UNL0;
         end
         S_PL1: begin
            mem_req.rd   = 1'b1;
            mem_req.addr = p_ff - WSIZE;
            state_in     = S_PL2;
         end
         S_PL2: begin
            size_in    = sz;
            sub_bp_in  = p_ff;
            sub_tag_in = 1'b1;
            state_in   = S_MARK0;
            if (sz >= need_ff && sz - need_ff >= MIN_BLOCK) begin
               sub_size_in = need_ff;
               out_gr_in   = need_ff[16:0];
               ret_in      = S_PL3;
            end else begin
               sub_size_in = sz;
               out_gr_in   = sz[16:0];
               ret_in      = S_PLDONE;
            end
         end
         S_PL3: begin
            sub_bp_in   = p_ff + need_ff;
            sub_size_in = size_ff - need_ff;
            sub_tag_in  = 1'b0;
            ret_in      = S_PL4;
            state_in    = S_MARK0;
         end
         S_PL4: begin
            sub_bp_in = p_ff + need_ff;
            ret_in    = S_PLDONE;
            state_in  = S_PUSH0;
         end
         S_PLDONE: begin
            out_pay_in   = p_ff[15:0];
            out_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         // free checks
         S_F0: begin
            if (mbp_ff != '0 && (mbp_ff & TAG_MASK) == '0 && mbp_ff >= START_END
                && mbp_ff < hend) begin
               mem_req.rd   = 1'b1;
               mem_req.addr = mbp_ff - WSIZE;
               state_in     = S_F1;
            end else begin
               out_st_in    = ST_FREE_IGNORED;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_F1: begin
            hdr_in  = rdv;
            size_in = sz;
            if (rdv[0] && sz >= MIN_BLOCK && sz <= hend - mbp_ff) begin
               mem_req.rd   = 1'b1;
               mem_req.addr = mbp_ff + sz - DSIZE;
               state_in     = S_F2;
            end else begin
               out_st_in    = ST_FREE_IGNORED;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_F2: begin
            if (rdv != hdr_ff) begin
               out_st_in    = ST_FREE_IGNORED;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               sub_bp_in   = mbp_ff;
               sub_size_in = size_ff;
               sub_tag_in  = 1'b0;
               ret_in      = S_F3;
               state_in    = S_MARK0;
            end
         end
         S_F3: begin
            sub_bp_in = mbp_ff;
            ret_in    = S_M0;
            state_in  = S_PUSH0;
         end
         // header and footer write
         S_MARK0: begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = sub_bp_ff - WSIZE;
            mem_req.wdata = sub_size_ff | word_type'(sub_tag_ff);
            state_in      = S_MARK1;
         end
         S_MARK1: begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = sub_bp_ff + sub_size_ff - DSIZE;
            mem_req.wdata = sub_size_ff | word_type'(sub_tag_ff);
            state_in      = ret_ff;
         end
         // push at the head of the block's class list
         S_PUSH0: begin
            mem_req.rd   = 1'b1;
            mem_req.addr = sub_bp_ff - WSIZE;
            state_in     = S_PUSH1;
         end
         S_PUSH1: begin
            cv            = class_of(sz);
            succ_in       = heads_ff[cv];
            heads_in[cv]  = sub_bp_ff;
            mem_req.wr    = 1'b1;
            mem_req.addr  = sub_bp_ff + WSIZE;
            mem_req.wdata = heads_ff[cv];
            state_in      = S_PUSH2;
         end
         S_PUSH2: begin
            mem_req.wr   = 1'b1;
            mem_req.addr = sub_bp_ff;
            state_in     = S_PUSH3;
         end
         S_PUSH3: begin
            mem_req.wr    = (succ_ff != '0);
            mem_req.addr  = succ_ff;
            mem_req.wdata = sub_bp_ff;
            state_in      = ret_ff;
         end
         // unlink from its list
         S_UNL0: begin
            mem_req.rd   = 1'b1;
            mem_req.addr = sub_bp_ff;
            state_in     = S_UNL1;
         end
         S_UNL1: begin
            pred_in      = rdv;
            mem_req.rd   = 1'b1;
            mem_req.addr = sub_bp_ff + WSIZE;
            state_in     = S_UNL2;
         end
         S_UNL2: begin
            succ_in = rdv;
            if (pred_ff != '0) begin
               mem_req.wr    = 1'b1;
               mem_req.addr  = pred_ff + WSIZE;
               mem_req.wdata = rdv;
               state_in      = S_UNL4;
            end else begin
               mem_req.rd   = 1'b1;
               mem_req.addr = sub_bp_ff - WSIZE;
               state_in     = S_UNL3;
            end
         end
         S_UNL3: begin
            cv           = class_of(sz);
            heads_in[cv] = succ_ff;
            state_in     = S_UNL4;
         end
         S_UNL4: begin
            mem_req.wr    = (succ_ff != '0);
            mem_req.addr  = succ_ff;
            mem_req.wdata = pred_ff;
            state_in      = S_UNL5;
         end
         S_UNL5: begin
            mem_req.wr   = 1'b1;
            mem_req.addr = sub_bp_ff;
            state_in     = S_UNL6;
         end
         S_UNL6: begin
            mem_req.wr   = 1'b1;
            mem_req.addr = sub_bp_ff + WSIZE;
            state_in     = ret_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
         heap_end_ff  <= END_W'(START_END);
         for (int i = 0; i < SIZE_CLASSES; i++) heads_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         out_valid_ff <= out_valid_in;
         heap_end_ff  <= heap_end_in;
         heads_ff     <= heads_in;
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      cmd_ff       <= cmd_in;
      req_bytes_ff <= req_bytes_in;
      need_ff      <= need_in;
      cls_ff       <= cls_in;
      budget_ff    <= budget_in;
      p_ff         <= p_in;
      mbp_ff       <= mbp_in;
      size_ff      <= size_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      pa_ff        <= pa_in;
      na_ff        <= na_in;
      hdr_ff       <= hdr_in;
      sub_bp_ff    <= sub_bp_in;
      sub_size_ff  <= sub_size_in;
      sub_tag_ff   <= sub_tag_in;
      pred_ff      <= pred_in;
      succ_ff      <= succ_in;
      out_pay_ff   <= out_pay_in;
      out_gr_ff    <= out_gr_in;
      out_st_ff    <= out_st_in;
   end

endmodule

`default_nettype wire

/* src/sfha_checker.sv */
// port-level checks of the heap allocator and their bind to the top level
`default_nettype none

module sfha_checker import sfha_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] payload_offset,
   input logic [16:0] granted_bytes,
   input logic [1:0]  status
);

   // failures carry no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_DONE |-> payload_offset == '0 && granted_bytes == '0)
      else $error("failed request carries a block");

   // granted sizes keep double-word alignment
   a_gr_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_DONE |-> granted_bytes[2:0] == 3'd0)
      else $error("granted size not a multiple of 8");

   // a new request is only taken when the response register can free up
   a_ready_slot: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while response stalled");

   // a response appears only after the block was busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without busy cycle");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_offset)
         && $stable(granted_bytes) && $stable(status))
      else $error("stalled response changed");

endmodule

bind segregated_fit_heap_allocator_core sfha_checker u_sfha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .payload_offset (rsp_chan.payload_offset),
   .granted_bytes  (rsp_chan.granted_bytes),
   .status         (rsp_chan.status)
);

`default_nettype wire

/* bench/tb_top.sv */
// self-checking testbench of the segregated-fit heap allocator core
module tb_top;
   import sfha_pkg::*;

   localparam int HEAP_BYTES   = 65536;
   localparam int SIZE_CLASSES = 14;
   localparam int HEAP_WORDS   = HEAP_BYTES / 4;
   localparam int RANDOM_COUNT = 1930;
   localparam int IDLE_LIMIT   = 100000;
   localparam int HOLD_CYCLES  = 3000;

   typedef struct {
      command_type cmd;
      logic [15:0] bytes;
      logic [15:0] offset;
      int          gap;
      bit          drain;
   } alloc_request_type;

   typedef struct {
      logic [15:0] payload;
      logic [16:0] granted;
      status_type  status;
   } grant_type;

   logic clock;
   logic reset;

   sfha_req_if req_bus ();
   sfha_rsp_if rsp_bus ();

   segregated_fit_heap_allocator_core #(
      .HEAP_BYTES   (HEAP_BYTES),
      .SIZE_CLASSES (SIZE_CLASSES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow heap of the allocator
   word_type    shadow_heap [HEAP_WORDS];
   bit          word_written [HEAP_WORDS];
   word_type    free_heads [SIZE_CLASSES];
   word_type    heap_top;

   alloc_request_type pending_requests [$];
   grant_type         expected_grants [$];
   int unsigned       live_blocks [$];
   int unsigned       freed_blocks [$];

   int          sent_count;
   int          rsp_count;
   int          error_count;
   int          gap_count;
   int          stall_left;
   int          stall_next;
   int          hold_left;
   bit          hold_done;
   int          idle_cycles;

   // clock and reset
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.block_offset = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic word_type heap_read(word_type off);
      word_type idx;
      idx = off >> 2;
      return (idx < HEAP_WORDS) ? shadow_heap[idx] : '0;
   endfunction

   function automatic void heap_write(word_type off, word_type val);
      word_type idx;
      idx = off >> 2;
      if (idx < HEAP_WORDS) begin
         shadow_heap[idx] = val;
         word_written[idx] = 1'b1;
      end
   endfunction

   function automatic word_type size_at(word_type bp);
      return heap_read(bp - WSIZE) & ~TAG_MASK;
   endfunction

   function automatic bit used_at(word_type bp);
      return (heap_read(bp - WSIZE) & 32'd1) != '0;
   endfunction

   function automatic int size_class(word_type s);
      int c;
      c = 0;
      while (c < SIZE_CLASSES - 1 && (64'd1 << c) < 64'(s))
         c++;
      return c;
   endfunction

   function automatic void set_tags(word_type bp, word_type size, bit used);
      heap_write(bp - WSIZE, size | used);
      heap_write(bp + size - DSIZE, size | used);
   endfunction

   function automatic void push_free(word_type bp);
      int       c;
      word_type succ;
      c = size_class(size_at(bp));
      succ = free_heads[c];
      heap_write(bp + WSIZE, succ);
      heap_write(bp, '0);
      free_heads[c] = bp;
      if (succ != 0)
         heap_write(succ, bp);
   endfunction

   function automatic void drop_free(word_type bp);
      word_type pred;
      word_type succ;
      pred = heap_read(bp);
      succ = heap_read(bp + WSIZE);
      if (pred != 0)
         heap_write(pred + WSIZE, succ);
      else
         free_heads[size_class(size_at(bp))] = succ;
      if (succ != 0)
         heap_write(succ, pred);
      heap_write(bp, '0);
      heap_write(bp + WSIZE, '0);
   endfunction

   function automatic word_type coalesce(word_type bp);
      word_type size;
      word_type prev;
      word_type next;
      bit       prev_used;
      bit       next_used;
      size = size_at(bp);
      prev = bp - (heap_read(bp - DSIZE) & ~TAG_MASK);
      next = bp + size;
      prev_used = used_at(prev);
      next_used = used_at(next);
      if (prev_used && next_used)
         return bp;
      if (!prev_used)
         drop_free(prev);
      drop_free(bp);
      if (!next_used) begin
         drop_free(next);
         size += size_at(next);
      end
      if (!prev_used) begin
         size += size_at(prev);
         bp = prev;
      end
      set_tags(bp, size, 1'b0);
      push_free(bp);
      return bp;
   endfunction

   function automatic word_type carve(word_type bp, word_type need);
      word_type size;
      drop_free(bp);
      size = size_at(bp);
      if (size >= need && size - need >= MIN_BLOCK) begin
         set_tags(bp, need, 1'b1);
         set_tags(bp + need, size - need, 1'b0);
         push_free(bp + need);
         return need;
      end
      set_tags(bp, size, 1'b1);
      return size;
   endfunction

   // free checks, as the block applies them
   function automatic bit free_accepted(word_type bp);
      word_type hdr;
      word_type size;
      if (bp == 0 || (bp & TAG_MASK) != 0 || bp < START_END || bp >= heap_top)
         return 1'b0;
      hdr = heap_read(bp - WSIZE);
      size = hdr & ~TAG_MASK;
      return hdr[0] && size >= MIN_BLOCK && size <= heap_top - bp
             && heap_read(bp + size - DSIZE) == hdr;
   endfunction

   // true when the free checks would only look at words written since reset
   function automatic bit free_reads_known(word_type bp);
      word_type hdr;
      word_type size;
      if (bp == 0 || (bp & TAG_MASK) != 0 || bp < START_END || bp >= heap_top)
         return 1'b1;
      if (!word_written[(bp - WSIZE) >> 2])
         return 1'b0;
      hdr = heap_read(bp - WSIZE);
      size = hdr & ~TAG_MASK;
      if (hdr[0] && size >= MIN_BLOCK && size <= heap_top - bp)
         return word_written[(bp + size - DSIZE) >> 2];
      return 1'b1;
   endfunction

   function automatic grant_type predict_grant(command_type cmd, logic [15:0] bytes,
                                               logic [15:0] offset);
      grant_type g;
      word_type  need;
      word_type  found;
      word_type  p;
      int        budget;
      g.payload = '0;
      g.granted = '0;
      g.status = ST_DONE;
      found = '0;
      if (cmd == CMD_ALLOC) begin
         if (bytes == 0) begin
            g.status = ST_ZERO_SIZE;
         end else begin
            need = (bytes <= SMALL_LIMIT) ? MIN_BLOCK : ((32'(bytes) + ROUND_ADD) & ~TAG_MASK);
            budget = HEAP_BYTES / 8;
            // first fit from the request's class upward
            for (int c = size_class(need); c < SIZE_CLASSES && found == 0; c++) begin
               p = free_heads[c];
               while (p != 0 && budget != 0) begin
                  budget--;
                  if (size_at(p) >= need) begin
                     found = p;
                     break;
                  end
                  p = heap_read(p + WSIZE);
               end
            end
            // grow the heap on a miss
            if (found == 0) begin
               if (need > HEAP_BYTES - heap_top) begin
                  g.status = ST_NO_MEMORY;
               end else begin
                  p = heap_top;
                  set_tags(p, need, 1'b0);
                  heap_write(p + need - WSIZE, EPILOGUE_TAG);
                  heap_top += need;
                  push_free(p);
                  found = coalesce(p);
               end
            end
            if (found != 0) begin
               g.granted = 17'(carve(found, need));
               g.payload = 16'(found);
            end
         end
      end else if (!free_accepted(offset)) begin
         g.status = ST_FREE_IGNORED;
      end else begin
         set_tags(offset, size_at(offset), 1'b0);
         push_free(offset);
         void'(coalesce(offset));
      end
      return g;
   endfunction

   task automatic queue_request(command_type cmd, int bytes, int offset, bit drain = 1'b0);
      alloc_request_type r;
      grant_type         g;
      r.cmd = cmd;
      r.bytes = 16'(bytes);
      r.offset = 16'(offset);
      r.drain = drain;
      r.gap = (pending_requests.size() % 200 < 40) ? 0 : $urandom_range(0, 14);
      g = predict_grant(r.cmd, r.bytes, r.offset);
      pending_requests.push_back(r);
      expected_grants.push_back(g);
      if (cmd == CMD_ALLOC && g.status == ST_DONE)
         live_blocks.push_back(g.payload);
   endtask

   task automatic queue_live_free();
      int idx;
      int unsigned bp;
      idx = $urandom_range(0, live_blocks.size() - 1);
      bp = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(bp);
      queue_request(CMD_FREE, 0, bp);
   endtask

   // stray free whose checks only see written words
   task automatic queue_stray_free(int unsigned bp);
      int tries;
      tries = 0;
      while (!free_reads_known(bp) && tries < 20) begin
         bp = $urandom_range(0, 65535) & ~32'h7;
         tries++;
      end
      if (!free_reads_known(bp))
         bp = 0;
      queue_request(CMD_FREE, 0, bp);
   endtask

   // stimulus build, then wait for the end of the run
   initial begin
      int pick;
      int bytes;
      for (int i = 0; i < HEAP_WORDS; i++) begin
         shadow_heap[i] = '0;
         word_written[i] = 1'b0;
      end
      for (int c = 0; c < SIZE_CLASSES; c++)
         free_heads[c] = '0;
      heap_write(WSIZE, PROLOGUE_TAG);
      heap_write(DSIZE, PROLOGUE_TAG);
      heap_write(12, EPILOGUE_TAG);
      heap_top = START_END;

      // directed: extremes, rejects, split, coalesce both ways
      queue_request(CMD_ALLOC, 0, 16'hFFFF);
      queue_request(CMD_FREE, 16'hFFFF, 0);
      queue_request(CMD_FREE, 0, 16);
      queue_request(CMD_ALLOC, 65535, 0);
      queue_request(CMD_ALLOC, 1, 0);
      queue_request(CMD_ALLOC, 16, 0);
      queue_request(CMD_ALLOC, 17, 0);
      queue_request(CMD_ALLOC, 200, 0);
      queue_request(CMD_ALLOC, 40, 0);
      queue_request(CMD_FREE, 0, 13);
      queue_request(CMD_FREE, 0, 65528);
      queue_request(CMD_FREE, 0, 16'h8000);
      queue_request(CMD_FREE, 0, 40);
      queue_request(CMD_FREE, 0, 40);
      queue_request(CMD_FREE, 0, 16);
      queue_request(CMD_FREE, 0, 96);
      queue_request(CMD_ALLOC, 8, 0);
      queue_request(CMD_ALLOC, 4000, 0);
      queue_request(CMD_FREE, 0, 64);
      queue_request(CMD_ALLOC, 30000, 0);
      queue_request(CMD_ALLOC, 30000, 0);
      queue_request(CMD_ALLOC, 100, 0);
      live_blocks.delete();
      queue_request(CMD_FREE, 0, 64);
      queue_request(CMD_FREE, 0, 16);

      // random traffic, mostly well-formed alloc and free of live blocks
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         pick = $urandom_range(0, 99);
         if ((i == 600 || i == 1300) && live_blocks.size() > 0)
            queue_request(CMD_FREE, 0, live_blocks.pop_front(), 1'b1);
         else if (pick < 45 || (pick < 80 && live_blocks.size() == 0)) begin
            case ($urandom_range(0, 9))
               0:       bytes = $urandom_range(0, 65535);
               1:       bytes = $urandom_range(1, 6000);
               2:       bytes = $urandom_range(0, 16);
               default: bytes = $urandom_range(1, 300);
            endcase
            queue_request(CMD_ALLOC, bytes, $urandom_range(0, 65535));
         end else if (pick < 80) begin
            queue_live_free();
         end else if (pick < 88 && freed_blocks.size() > 0) begin
            queue_stray_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
         end else if (pick < 94) begin
            queue_stray_free($urandom_range(0, 65535));
         end else begin
            queue_stray_free(($urandom_range(0, heap_top) + 16) & ~32'h7);
         end
      end

      @(posedge clock);
      while (reset || pending_requests.size() != 0 || rsp_count != sent_count)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_grants.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_count <= 0;
         sent_count <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid)
            sent_count <= sent_count + 1;
         if (pending_requests.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (gap_count < pending_requests[0].gap
                      || (pending_requests[0].drain
                          && rsp_count != sent_count + int'(req_bus.valid))) begin
            req_bus.valid <= 1'b0;
            gap_count <= gap_count + 1;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.command <= pending_requests[0].cmd;
            req_bus.request_bytes <= pending_requests[0].bytes;
            req_bus.block_offset <= pending_requests[0].offset;
            void'(pending_requests.pop_front());
            gap_count <= 0;
         end
      end
   end

   // long receiver hold-off, once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && rsp_count == 400) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
         rsp_count <= 0;
      end else begin
         stall_next = stall_left;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected response offset=%0d bytes=%0d status=%0d", $time,
                        rsp_bus.payload_offset, rsp_bus.granted_bytes, rsp_bus.status);
               error_count++;
            end else begin
               if (rsp_bus.payload_offset !== expected_grants[0].payload) begin
                  $display("%0t: payload_offset expected %0d actual %0d", $time,
                           expected_grants[0].payload, rsp_bus.payload_offset);
                  error_count++;
               end
               if (rsp_bus.granted_bytes !== expected_grants[0].granted) begin
                  $display("%0t: granted_bytes expected %0d actual %0d", $time,
                           expected_grants[0].granted, rsp_bus.granted_bytes);
                  error_count++;
               end
               if (rsp_bus.status !== expected_grants[0].status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           expected_grants[0].status, rsp_bus.status);
                  error_count++;
               end
               void'(expected_grants.pop_front());
            end
            rsp_count <= rsp_count + 1;
            stall_next = (rsp_count % 200 < 40) ? 0 : $urandom_range(0, 14);
         end else if (stall_next > 0) begin
            stall_next = stall_next - 1;
         end
         stall_left <= stall_next;
         rsp_bus.ready <= (stall_next == 0 && hold_left == 0);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
   end

endmodule
